@@ sv/jzdi_pkg.sv @@
// shared types, tables and constants of the 8x8 dequantize and inverse dct block
`timescale 1ns / 1ps

package jzdi_pkg;

    localparam int COEF_BITS_DEF = 12;
    localparam int COS_FRAC_DEF  = 15;
    localparam int VAL_W         = 20;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int QROWS         = 8;
    localparam logic [CFG_W-1:0] QUANT_RST = 64'h0101010101010101;

    typedef enum logic [2:0]
    {
        K_NOP,
        K_RAW,
        K_DEQ,
        K_P1,
        K_LO,
        K_HI
    } kind_t;

    // one command word per cycle from the controller to the datapath
    typedef struct packed
    {
        logic       store;
        logic       clear;
        kind_t      kind;
        logic [5:0] addr;
        logic [2:0] bx;
        logic [2:0] bu;
        logic       first;
        logic       fin;
        logic [5:0] waddr;
        logic       lastv;
    } cmd_t;

    localparam logic [5:0] ZZ_POS [64] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    // cos(k*pi/16) with 30 fraction bits
    localparam longint COS30 [9] = '{
        64'sd1073741824, 64'sd1053110176, 64'sd992008094, 64'sd892783698,
        64'sd759250125,  64'sd596538995,  64'sd410903207, 64'sd209476638, 64'sd0
    };
    localparam longint SQRT_HALF_30 = 64'sd759250125;

    // c(u)*cos((2x+1)u*pi/16) rounded to frac fraction bits
    function automatic int basis_val(input logic [2:0] x, input logic [2:0] u,
                                     input int frac);
        int     k;
        int     sh;
        logic   neg;
        longint v;
        longint mag;
        neg = 1'b0;
        sh  = 30 - frac;
        if (u == 3'd0)
        begin
            v = SQRT_HALF_30;
        end
        else
        begin
            k = ((2 * int'(x) + 1) * int'(u)) & 31;
            if (k > 16)
                k = 32 - k;
            if (k > 8)
            begin
                k   = 16 - k;
                neg = 1'b1;
            end
            v = COS30[k];
        end
        mag = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        return neg ? -int'(mag) : int'(mag);
    endfunction

endpackage

@@ sv/jzdi_ctrl.sv @@
// controller: sequences storing, emitting and the two idct passes
`timescale 1ns / 1ps

module jzdi_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last_coef,
    input  logic [1:0]       output_mode,
    output logic             busy,
    output jzdi_pkg::cmd_t   cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EMIT,
        S_PASS1,
        S_DRAIN,
        S_PASS2,
        S_FLUSH
    } state_t;

    localparam logic [10:0] DRAIN_LAST = 11'd4;
    localparam logic [10:0] FLUSH_LAST = 11'd6;

    state_t      state_reg, state_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        raw_reg, raw_next;
    logic        busy_reg, busy_next;
    logic        accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 11'd1;
        raw_next   = raw_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        cmd.kind   = jzdi_pkg::K_NOP;
        cmd.store  = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept && last_coef)
                begin
                    busy_next = 1'b1;
                    raw_next  = (output_mode == 2'd0);
                    if (output_mode == 2'd0 || output_mode == 2'd1)
                        state_next = S_EMIT;
                    else
                        state_next = S_PASS1;
                end
            end
            S_EMIT:
            begin
                cmd.kind  = raw_reg ? jzdi_pkg::K_RAW : jzdi_pkg::K_DEQ;
                cmd.addr  = cnt_reg[5:0];
                cmd.lastv = (cnt_reg[5:0] == 6'd63);
                if (cnt_reg[5:0] == 6'd63)
                begin
                    state_next = S_FLUSH;
                    cnt_next   = '0;
                end
            end
            S_PASS1:
            begin
                // row u, output column j, term v
                cmd.kind  = jzdi_pkg::K_P1;
                cmd.addr  = {cnt_reg[8:6], cnt_reg[2:0]};
                cmd.bx    = cnt_reg[5:3];
                cmd.bu    = cnt_reg[2:0];
                cmd.first = (cnt_reg[2:0] == 3'd0);
                cmd.fin   = (cnt_reg[2:0] == 3'd7);
                cmd.waddr = {cnt_reg[8:6], cnt_reg[5:3]};
                if (cnt_reg[8:0] == 9'd511)
                begin
                    state_next = S_DRAIN;
                    cnt_next   = '0;
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = S_PASS2;
                    cnt_next   = '0;
                end
            end
            S_PASS2:
            begin
                // pixel row i, column j, term u, low then high half
                cmd.kind  = cnt_reg[0] ? jzdi_pkg::K_HI : jzdi_pkg::K_LO;
                cmd.addr  = {cnt_reg[3:1], cnt_reg[6:4]};
                cmd.bx    = cnt_reg[9:7];
                cmd.bu    = cnt_reg[3:1];
                cmd.first = (cnt_reg[3:0] == 4'd0);
                cmd.fin   = (cnt_reg[3:0] == 4'd15);
                cmd.lastv = (cnt_reg[9:4] == 6'd63);
                if (cnt_reg[9:0] == 10'd1023)
                begin
                    state_next = S_FLUSH;
                    cnt_next   = '0;
                end
            end
            S_FLUSH:
            begin
                if (cnt_reg == FLUSH_LAST)
                begin
                    cmd.clear  = 1'b1;
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            raw_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            raw_reg   <= raw_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

@@ sv/jzdi_dp.sv @@
// datapath: coefficient store, quantizer registers, shared mac and output rounding
`timescale 1ns / 1ps

module jzdi_dp
#(
    parameter int COEF_BITS     = jzdi_pkg::COEF_BITS_DEF,
    parameter int COS_FRAC_BITS = jzdi_pkg::COS_FRAC_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jzdi_pkg::cmd_t                       cmd,
    input  logic signed [COEF_BITS-1:0]          coefficient,
    input  logic                                 cfg_we,
    input  logic [jzdi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jzdi_pkg::CFG_W-1:0]           cfg_data,
    output logic signed [jzdi_pkg::VAL_W-1:0]    value,
    output logic                                 last_value,
    output logic                                 result_valid
);

    localparam int DEQ_W  = COEF_BITS + 8;
    localparam int BAS_W  = COS_FRAC_BITS + 2;
    localparam int S_W    = DEQ_W + BAS_W + 3;
    localparam int LO_W   = (S_W + 1) / 2;
    localparam int OP_W   = (DEQ_W > LO_W + 1) ? DEQ_W : LO_W + 1;
    localparam int PROD_W = OP_W + BAS_W;
    localparam int ACC_W  = S_W + BAS_W + 3;
    localparam int RND_D  = 2 * COS_FRAC_BITS + 2;
    localparam int VW     = jzdi_pkg::VAL_W;
    localparam longint OUT_MAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam longint OUT_MIN = -(64'sd1 <<< (VW - 1));
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (RND_D - 1);

    // storage
    logic [jzdi_pkg::CFG_W-1:0]   quant_reg [jzdi_pkg::QROWS];
    logic signed [COEF_BITS-1:0]  coef_mem [64];
    logic signed [S_W-1:0]        s_mem [64];
    logic [63:0]                  vld_reg;
    logic [6:0]                   fill_reg;

    // pipeline
    jzdi_pkg::cmd_t               cmd_b_reg, cmd_c_reg, cmd_d_reg;
    logic signed [COEF_BITS-1:0]  coef_rd_reg;
    logic                         vbit_reg;
    logic signed [S_W-1:0]        s_rd_reg;
    logic signed [DEQ_W-1:0]      deq_reg;
    logic signed [COEF_BITS-1:0]  raw_reg;
    logic signed [OP_W-1:0]       part_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [VW-1:0]         emit_reg;
    logic                         emit_v_reg, emit_last_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [ACC_W-1:0]      fin_reg;
    logic                         fin_v_reg, fin_last_reg;
    logic signed [VW-1:0]         value_reg;
    logic                         valid_reg, last_reg;

    logic signed [COEF_BITS-1:0]  coef_b;
    logic [7:0]                   q_b;
    logic signed [DEQ_W-1:0]      deq_next;
    logic signed [OP_W-1:0]       part_next;
    logic signed [OP_W-1:0]       op_c;
    logic signed [BAS_W-1:0]      bas_c;
    logic signed [VW-1:0]         emit_next;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      rnd_sum, q_sh;
    logic [7:0]                   pix;

    function automatic logic signed [VW-1:0] sat_val(input logic signed [DEQ_W-1:0] d);
        longint dl;
        dl = longint'(d);
        if (dl > OUT_MAX)
            dl = OUT_MAX;
        if (dl < OUT_MIN)
            dl = OUT_MIN;
        return dl[VW-1:0];
    endfunction

    // quantizer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < jzdi_pkg::QROWS; r++)
                quant_reg[r] <= jzdi_pkg::QUANT_RST;
        end
        else if (cfg_we)
        begin
            quant_reg[cfg_index] <= cfg_data;
        end
    end

    // valid bits and fill count; invalid entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            fill_reg <= '0;
        end
        else if (cmd.clear)
        begin
            vld_reg  <= '0;
            fill_reg <= '0;
        end
        else if (cmd.store && !fill_reg[6])
        begin
            vld_reg[jzdi_pkg::ZZ_POS[fill_reg[5:0]]] <= 1'b1;
            fill_reg <= fill_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && !fill_reg[6])
            coef_mem[jzdi_pkg::ZZ_POS[fill_reg[5:0]]] <= coefficient;
        coef_rd_reg <= coef_mem[cmd.addr];
        vbit_reg    <= vld_reg[cmd.addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_d_reg.kind == jzdi_pkg::K_P1 && cmd_d_reg.fin)
            s_mem[cmd_d_reg.waddr] <= acc_next[S_W-1:0];
        s_rd_reg <= s_mem[cmd.addr];
    end

    // stage b: dequantize and split the row-pass sum
    always_comb
    begin
        coef_b   = vbit_reg ? coef_rd_reg : '0;
        q_b      = quant_reg[cmd_b_reg.addr[5:3]][{cmd_b_reg.addr[2:0], 3'b000} +: 8];
        deq_next = DEQ_W'(coef_b * $signed({1'b0, q_b}));
        if (cmd_b_reg.kind == jzdi_pkg::K_HI)
            part_next = OP_W'($signed(s_rd_reg[S_W-1:LO_W]));
        else
            part_next = OP_W'($signed({1'b0, s_rd_reg[LO_W-1:0]}));
    end

    // stage c: the mac multiplier, and saturation of the emitted word
    always_comb
    begin
        op_c  = (cmd_c_reg.kind == jzdi_pkg::K_P1) ? OP_W'(deq_reg) : part_reg;
        bas_c = BAS_W'(jzdi_pkg::basis_val(cmd_c_reg.bx, cmd_c_reg.bu, COS_FRAC_BITS));
        if (cmd_c_reg.kind == jzdi_pkg::K_RAW)
            emit_next = VW'(raw_reg);
        else
            emit_next = sat_val(deq_reg);
    end

    // stage d: accumulate, high half weighted by 2^LO_W
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        if (cmd_d_reg.kind == jzdi_pkg::K_HI)
            prod_ext = prod_ext <<< LO_W;
        acc_next = (cmd_d_reg.first ? '0 : acc_reg) + prod_ext;
    end

    // stage e: round half away from zero, offset and clamp
    always_comb
    begin
        rnd_sum = fin_reg + $signed(HALF) - $signed({{(ACC_W-1){1'b0}}, fin_reg[ACC_W-1]});
        q_sh    = rnd_sum >>> RND_D;
        if (q_sh > $signed(ACC_W'(127)))
            pix = 8'd255;
        else if (q_sh < -$signed(ACC_W'(128)))
            pix = 8'd0;
        else
            pix = {~q_sh[7], q_sh[6:0]};
    end

    always_ff @(posedge clk)
    begin
        deq_reg  <= deq_next;
        raw_reg  <= coef_b;
        part_reg <= part_next;
        prod_reg <= op_c * bas_c;
        emit_reg <= emit_next;
        acc_reg  <= acc_next;
        if (cmd_d_reg.fin)
            fin_reg <= acc_next;
        if (fin_v_reg)
            value_reg <= VW'(pix);
        else
            value_reg <= emit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_b_reg     <= '0;
            cmd_c_reg     <= '0;
            cmd_d_reg     <= '0;
            emit_v_reg    <= 1'b0;
            emit_last_reg <= 1'b0;
            fin_v_reg     <= 1'b0;
            fin_last_reg  <= 1'b0;
            valid_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            cmd_b_reg     <= cmd;
            cmd_c_reg     <= cmd_b_reg;
            cmd_d_reg     <= cmd_c_reg;
            emit_v_reg    <= (cmd_c_reg.kind == jzdi_pkg::K_RAW) ||
                             (cmd_c_reg.kind == jzdi_pkg::K_DEQ);
            emit_last_reg <= cmd_c_reg.lastv;
            fin_v_reg     <= cmd_d_reg.fin && ((cmd_d_reg.kind == jzdi_pkg::K_LO) ||
                                               (cmd_d_reg.kind == jzdi_pkg::K_HI));
            fin_last_reg  <= cmd_d_reg.lastv;
            valid_reg     <= emit_v_reg || fin_v_reg;
            last_reg      <= fin_v_reg ? fin_last_reg : (emit_v_reg && emit_last_reg);
        end
    end

    assign value        = value_reg;
    assign last_value   = last_reg;
    assign result_valid = valid_reg;

endmodule

@@ sv/jpeg_block_zigzag_dequant_idct.sv @@
// top level of the 8x8 zigzag placement, dequantization and inverse dct block
//
//  channel   signals                                  handshake
//  input     coefficient, last_coef, output_mode      start && !busy
//  result    value, last_value                        result_valid, one cycle
//  config    cfg_index, cfg_data                      cfg_we, no wait
//
// an item without last_coef is stored and busy stays low.
// a last item raises busy: modes 0 and 1 stream 64 words, modes 2 and 3 run
// both idct passes on the single shared multiply-accumulate and stream 64 pixels
// (512 row-pass terms, 1024 half-width column-pass terms).
// reset clears the store, the quantizers go to 1; the receiver cannot stall.
`timescale 1ns / 1ps

module jpeg_block_zigzag_dequant_idct
#(
    parameter int COEF_BITS     = jzdi_pkg::COEF_BITS_DEF,
    parameter int COS_FRAC_BITS = jzdi_pkg::COS_FRAC_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COEF_BITS-1:0]          coefficient,
    input  logic                                 last_coef,
    input  logic [1:0]                           output_mode,
    output logic signed [jzdi_pkg::VAL_W-1:0]    value,
    output logic                                 last_value,
    output logic                                 result_valid,
    input  logic                                 cfg_we,
    input  logic [jzdi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jzdi_pkg::CFG_W-1:0]           cfg_data
);

    jzdi_pkg::cmd_t cmd;

    jzdi_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_coef   (last_coef),
        .output_mode (output_mode),
        .busy        (busy),
        .cmd         (cmd)
    );

    jzdi_dp
    #(
        .COEF_BITS     (COEF_BITS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .coefficient  (coefficient),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .value        (value),
        .last_value   (last_value),
        .result_valid (result_valid)
    );

endmodule

@@ sv/jzdi_check.sv @@
// port-level checks of the block, bound to the top level
`timescale 1ns / 1ps

module jzdi_check
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_coef,
    input logic last_value,
    input logic result_valid
);

    // words only come out while a block is being worked on
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result word outside a busy period");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_value |-> result_valid)
        else $error("last_value without a result word");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_coef) |=> busy)
        else $error("last word did not start output");

    a_plain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_coef) |=> !busy)
        else $error("plain word made the block busy");

endmodule

bind jpeg_block_zigzag_dequant_idct jzdi_check u_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_coef    (last_coef),
    .last_value   (last_value),
    .result_valid (result_valid)
);
